FILE: rtl/core/nsc_pkg.sv
// ============================================================================
// nsc_pkg - NMEA sentence checker shared definitions
// Character codes, result codes, per-sentence state and the body-byte update.
// ============================================================================
package nsc_pkg;

    // Saturation limits of the sentence counters
    localparam int MAX_FIELDS  = 40;
    localparam int LENGTH_BITS = 10;

    localparam int COMMA_BITS   = $clog2(MAX_FIELDS);
    localparam int OUT_LEN_BITS = 10;
    localparam int FIELD_BITS   = 6;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [LENGTH_BITS-1:0]  LEN_MAX     = '1;
    localparam logic [COMMA_BITS-1:0]   COMMA_MAX   = COMMA_BITS'(MAX_FIELDS - 1);
    localparam logic [OUT_LEN_BITS-1:0] OUT_LEN_MAX = '1;

    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_STAR  = 8'h2A;
    localparam logic [7:0] CHR_COMMA = 8'h2C;

    // First-field letters three to five, letter three in the low byte
    localparam logic [23:0] LETTERS_GGA = 24'h414747;
    localparam logic [23:0] LETTERS_ATT = 24'h545441;
    localparam logic [23:0] LETTERS_GSV = 24'h565347;
    localparam logic [23:0] LETTERS_RMC = 24'h434D52;

    localparam logic [7:0] START_CHAR_RST   = 8'd36;
    localparam logic [7:0] MIN_BODY_LEN_RST = 8'd6;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_START_CHAR   = 1'b0,
        CFG_MIN_BODY_LEN = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_SHORT = 2'd1,
        STATUS_STARS = 2'd2,
        STATUS_CKSUM = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        MSG_OTHER = 3'd0,
        MSG_GGA   = 3'd1,
        MSG_ATT   = 3'd2,
        MSG_GSV   = 3'd3,
        MSG_RMC   = 3'd4
    } msg_type_t;

    typedef struct packed {
        logic                   in_sentence;
        logic [7:0]             xor_acc;
        logic [1:0]             star_seen;
        logic [7:0]             hex_acc;
        logic                   hex_stopped;
        logic [LENGTH_BITS-1:0] length_count;
        logic [COMMA_BITS-1:0]  comma_count;
        logic [23:0]            type_letters;
    } sent_state_t;

    // Bit 4 flags a hex digit, bits 3:0 give its value
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] d;
        d = 5'd0;
        if (b inside {[8'h30:8'h39]}) begin
            d = {1'b1, 4'(b - 8'h30)};
        end
        else if (b inside {[8'h41:8'h46]}) begin
            d = {1'b1, 4'(b - 8'h37)};
        end
        else if (b inside {[8'h61:8'h66]}) begin
            d = {1'b1, 4'(b - 8'h57)};
        end
        return d;
    endfunction

    // Fold one body byte into the sentence state
    function automatic sent_state_t take_body(input sent_state_t s, input logic [7:0] b);
        sent_state_t n;
        logic [4:0]  hx;
        n  = s;
        hx = hex_digit(b);
        if (s.in_sentence) begin
            if (s.length_count != LEN_MAX) begin
                n.length_count = s.length_count + 1'b1;
            end
            if (s.star_seen == 2'd0) begin
                if (b == CHR_STAR) begin
                    n.star_seen = 2'd1;
                end
                else begin
                    n.xor_acc = s.xor_acc ^ b;
                    if (b == CHR_COMMA) begin
                        if (s.comma_count != COMMA_MAX) begin
                            n.comma_count = s.comma_count + 1'b1;
                        end
                    end
                    else if (s.comma_count == '0) begin
                        if (s.length_count == LENGTH_BITS'(2)) begin
                            n.type_letters[7:0] = b;
                        end
                        else if (s.length_count == LENGTH_BITS'(3)) begin
                            n.type_letters[15:8] = b;
                        end
                        else if (s.length_count == LENGTH_BITS'(4)) begin
                            n.type_letters[23:16] = b;
                        end
                    end
                end
            end
            else if (b == CHR_STAR) begin
                if (s.star_seen != 2'd2) begin
                    n.star_seen = s.star_seen + 2'd1;
                end
                n.hex_stopped = 1'b1;
            end
            else if (!s.hex_stopped) begin
                if (hx[4]) begin
                    n.hex_acc = {s.hex_acc[3:0], hx[3:0]};
                end
                else begin
                    n.hex_stopped = 1'b1;
                end
            end
        end
        return n;
    endfunction

endpackage

FILE: rtl/core/nsc_if.sv
// ============================================================================
// nsc_if - NMEA sentence checker channels
// Valid/ready channels for received bytes and for sentence results.
// ============================================================================
interface nsc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nsc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [2:0] msg_type;
    logic [9:0] body_length;
    logic [5:0] field_count;
    logic [7:0] computed_xor;
    logic [7:0] received_sum;

    modport source (
        output valid, output status, output msg_type, output body_length,
        output field_count, output computed_xor, output received_sum,
        input ready
    );
    modport sink (
        input valid, input status, input msg_type, input body_length,
        input field_count, input computed_xor, input received_sum,
        output ready
    );
endinterface

FILE: rtl/core/nmea_sentence_checker_unit.sv
// A result beat is offered once the LF byte held in the byte register has been evaluated into the result register.
// Throughput: one byte per cycle while the result register is free or being taken.
// A byte register feeds one pass of logic into the result register; both
// advance together whenever the result register is empty or being taken.
// Reset clears all sentence state and loads start_char = '$', min length = 6.
// ============================================================================
// nmea_sentence_checker_unit - NMEA 0183 sentence checksum validator
// Tracks length, XOR, star count, hex checksum, fields and type per sentence
// and gives one result beat at each CR LF.
// ============================================================================
module nmea_sentence_checker_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    nsc_in_if.sink                           rx,
    nsc_out_if.source                        result,
    input  logic                             cfg_we,
    input  logic [nsc_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [7:0]                       cfg_wdata
);

    // Configuration registers
    logic [7:0] start_char_reg;
    logic [7:0] min_len_reg;

    // Byte register stage
    logic       in_vld_reg;
    logic       in_vld_next;
    logic [7:0] byte_reg;

    // Sentence state
    nsc_pkg::sent_state_t st_reg;
    nsc_pkg::sent_state_t st_next;
    logic                 prev_cr_reg;
    logic                 prev_cr_next;

    // Result register
    logic                                res_vld_reg;
    logic                                res_vld_next;
    nsc_pkg::status_t                    status_reg;
    nsc_pkg::status_t                    status_next;
    nsc_pkg::msg_type_t                  msg_type_reg;
    nsc_pkg::msg_type_t                  msg_type_next;
    logic [nsc_pkg::OUT_LEN_BITS-1:0]    body_len_reg;
    logic [nsc_pkg::OUT_LEN_BITS-1:0]    body_len_next;
    logic [nsc_pkg::FIELD_BITS-1:0]      field_cnt_reg;
    logic [nsc_pkg::FIELD_BITS-1:0]      field_cnt_next;
    logic [7:0]                          xor_reg;
    logic [7:0]                          hex_reg;

    // Control
    logic                 advance;
    logic                 proc_en;
    logic                 is_term;
    logic                 too_short;
    logic [15:0]          len_wide;
    nsc_pkg::sent_state_t st_cr;
    nsc_pkg::sent_state_t st_clear;

    // Advance the pipe when the result slot is free or being drained
    assign advance  = !res_vld_reg || result.ready;
    assign proc_en  = in_vld_reg && advance;
    assign rx.ready = !in_vld_reg || advance;

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_char_reg <= nsc_pkg::START_CHAR_RST;
            min_len_reg    <= nsc_pkg::MIN_BODY_LEN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                nsc_pkg::CFG_START_CHAR:   start_char_reg <= cfg_wdata;
                nsc_pkg::CFG_MIN_BODY_LEN: min_len_reg    <= cfg_wdata;
                default:                   ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Byte register
    // ------------------------------------------------------------------
    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (rx.ready)
        begin
            in_vld_next = rx.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            byte_reg <= rx.rx_byte;
        end
    end

    // ------------------------------------------------------------------
    // Sentence state update
    // ------------------------------------------------------------------
    // A CR held back from the last beat is a body byte unless LF follows now
    assign is_term = (byte_reg == nsc_pkg::CHR_LF) && prev_cr_reg;
    assign st_cr   = prev_cr_reg ? nsc_pkg::take_body(st_reg, nsc_pkg::CHR_CR) : st_reg;

    always_comb
    begin
        st_clear = '0;
        st_next  = st_reg;
        prev_cr_next = prev_cr_reg;
        if (proc_en)
        begin
            prev_cr_next = 1'b0;
            if (is_term)
            begin
                // Close the sentence
                st_next = st_clear;
            end
            else if (byte_reg == start_char_reg)
            begin
                // Open or reopen: drop everything gathered so far
                st_next = st_clear;
                st_next.in_sentence = 1'b1;
            end
            else if (byte_reg == nsc_pkg::CHR_CR)
            begin
                // Hold the CR until the next byte decides its role
                st_next = st_cr;
                prev_cr_next = 1'b1;
            end
            else
            begin
                st_next = nsc_pkg::take_body(st_cr, byte_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= '0;
            prev_cr_reg <= 1'b0;
        end
        else
        begin
            st_reg      <= st_next;
            prev_cr_reg <= prev_cr_next;
        end
    end

    // ------------------------------------------------------------------
    // Result evaluation from the state as it stands before the LF
    // ------------------------------------------------------------------
    assign len_wide  = 16'(st_reg.length_count);
    assign too_short = !st_reg.in_sentence || (len_wide == 16'd0)
                       || (len_wide < 16'(min_len_reg));

    always_comb
    begin
        if (too_short)
        begin
            status_next = nsc_pkg::STATUS_SHORT;
        end
        else if (st_reg.star_seen != 2'd1)
        begin
            status_next = nsc_pkg::STATUS_STARS;
        end
        else if (st_reg.hex_acc != st_reg.xor_acc)
        begin
            status_next = nsc_pkg::STATUS_CKSUM;
        end
        else
        begin
            status_next = nsc_pkg::STATUS_OK;
        end
    end

    always_comb
    begin
        msg_type_next = nsc_pkg::MSG_OTHER;
        if (status_next == nsc_pkg::STATUS_OK)
        begin
            case (st_reg.type_letters)
                nsc_pkg::LETTERS_GGA: msg_type_next = nsc_pkg::MSG_GGA;
                nsc_pkg::LETTERS_ATT: msg_type_next = nsc_pkg::MSG_ATT;
                nsc_pkg::LETTERS_GSV: msg_type_next = nsc_pkg::MSG_GSV;
                nsc_pkg::LETTERS_RMC: msg_type_next = nsc_pkg::MSG_RMC;
                default:              msg_type_next = nsc_pkg::MSG_OTHER;
            endcase
        end
    end

    // Clip the length to the result field
    assign body_len_next = (len_wide > 16'(nsc_pkg::OUT_LEN_MAX))
                           ? nsc_pkg::OUT_LEN_MAX
                           : nsc_pkg::OUT_LEN_BITS'(len_wide);
    assign field_cnt_next = nsc_pkg::FIELD_BITS'(st_reg.comma_count)
                            + nsc_pkg::FIELD_BITS'(1);

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_comb
    begin
        res_vld_next = res_vld_reg;
        if (advance)
        begin
            res_vld_next = proc_en && is_term;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else
        begin
            res_vld_reg <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_en && is_term)
        begin
            status_reg    <= status_next;
            msg_type_reg  <= msg_type_next;
            body_len_reg  <= body_len_next;
            field_cnt_reg <= field_cnt_next;
            xor_reg       <= st_reg.xor_acc;
            hex_reg       <= st_reg.hex_acc;
        end
    end

    assign result.valid        = res_vld_reg;
    assign result.status       = status_reg;
    assign result.msg_type     = msg_type_reg;
    assign result.body_length  = body_len_reg;
    assign result.field_count  = field_cnt_reg;
    assign result.computed_xor = xor_reg;
    assign result.received_sum = hex_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_term_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
        proc_en && is_term |=> res_vld_reg)
        else $error("terminator did not load a result beat");

    a_term_closes: assert property (@(posedge clk) disable iff (!rst_n)
        proc_en && is_term |=> !st_reg.in_sentence && !prev_cr_reg)
        else $error("sentence still open after CR LF");

    a_type_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld_reg && (status_reg != nsc_pkg::STATUS_OK)
            |-> msg_type_reg == nsc_pkg::MSG_OTHER)
        else $error("message type set on a rejected sentence");

    a_ok_sum_match: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld_reg && (status_reg == nsc_pkg::STATUS_OK) |-> xor_reg == hex_reg)
        else $error("accepted sentence with checksum mismatch");

    a_field_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld_reg |-> (field_cnt_reg != '0)
            && (field_cnt_reg <= nsc_pkg::FIELD_BITS'(nsc_pkg::MAX_FIELDS)))
        else $error("field count out of range");

endmodule

FILE: verif/nsc_verdict_monitor.sv
// ============================================================================
// nsc_verdict_monitor - sentence verdict predictor and result comparator
// Watches the byte and result channels and the register port, tracks the
// sentence state of the checker byte by byte, and compares every result
// beat field by field with the oldest predicted verdict.
// ============================================================================
module nsc_verdict_monitor (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic [7:0]                       in_byte,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic [1:0]                       out_status,
    input  logic [2:0]                       out_msg_type,
    input  logic [9:0]                       out_body_length,
    input  logic [5:0]                       out_field_count,
    input  logic [7:0]                       out_computed_xor,
    input  logic [7:0]                       out_received_sum,
    input  logic                             cfg_we,
    input  logic [nsc_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [7:0]                       cfg_wdata,
    output int                               fail_count,
    output int                               pending
);
    import nsc_pkg::*;

    localparam logic [LENGTH_BITS-1:0] LEN_SAT = '1;
    localparam logic [5:0]             COMMA_SAT = 6'(MAX_FIELDS - 1);
    localparam int                     REPORT_LEN_SAT = 1023;

    typedef struct packed {
        status_t    status;
        msg_type_t  msg_type;
        logic [9:0] body_length;
        logic [5:0] field_count;
        logic [7:0] computed_xor;
        logic [7:0] received_sum;
    } sentence_verdict_t;

    // Register copies
    logic [7:0] start_ch;
    logic [7:0] min_len;

    // Sentence state
    logic                   open_sent;
    logic                   cr_pending;
    logic [7:0]             xor_run;
    logic [1:0]             stars;
    logic [7:0]             cksum_run;
    logic                   cksum_done;
    logic [LENGTH_BITS-1:0] len_run;
    logic [5:0]             commas;
    logic [23:0]            letters;

    sentence_verdict_t verdicts_due[$];
    int                errs = 0;

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic clear_sentence();
        xor_run    = '0;
        stars      = '0;
        cksum_run  = '0;
        cksum_done = 1'b0;
        len_run    = '0;
        commas     = '0;
        letters    = '0;
    endtask

    task automatic fold_body(input logic [7:0] b);
        logic [LENGTH_BITS-1:0] pos;
        if (!open_sent) begin
            return;
        end
        pos = len_run;
        if (len_run != LEN_SAT) begin
            len_run = len_run + 1'b1;
        end
        if (stars == 2'd0) begin
            if (b == CHR_STAR) begin
                stars = 2'd1;
            end
            else begin
                xor_run = xor_run ^ b;
                if (b == CHR_COMMA) begin
                    if (commas != COMMA_SAT) begin
                        commas = commas + 1'b1;
                    end
                end
                else if (commas == '0 && pos >= 2 && pos <= 4) begin
                    letters[8*(pos-2) +: 8] = b;
                end
            end
        end
        else if (b == CHR_STAR) begin
            if (stars != 2'd2) begin
                stars = stars + 2'd1;
            end
            cksum_done = 1'b1;
        end
        else if (!cksum_done) begin
            // Upper or lower case hex; anything else ends the checksum
            if (b >= "0" && b <= "9") begin
                cksum_run = {cksum_run[3:0], 4'(b - "0")};
            end
            else if (b >= "A" && b <= "F") begin
                cksum_run = {cksum_run[3:0], 4'(b - "A" + 8'd10)};
            end
            else if (b >= "a" && b <= "f") begin
                cksum_run = {cksum_run[3:0], 4'(b - "a" + 8'd10)};
            end
            else begin
                cksum_done = 1'b1;
            end
        end
    endtask

    task automatic close_sentence();
        sentence_verdict_t v;
        if (!open_sent || len_run == '0 || len_run < min_len) begin
            v.status = STATUS_SHORT;
        end
        else if (stars != 2'd1) begin
            v.status = STATUS_STARS;
        end
        else if (cksum_run != xor_run) begin
            v.status = STATUS_CKSUM;
        end
        else begin
            v.status = STATUS_OK;
        end
        v.msg_type = MSG_OTHER;
        if (v.status == STATUS_OK) begin
            case ({letters[7:0], letters[15:8], letters[23:16]})
                "GGA":   v.msg_type = MSG_GGA;
                "ATT":   v.msg_type = MSG_ATT;
                "GSV":   v.msg_type = MSG_GSV;
                "RMC":   v.msg_type = MSG_RMC;
                default: v.msg_type = MSG_OTHER;
            endcase
        end
        v.body_length  = (int'(len_run) > REPORT_LEN_SAT) ? 10'(REPORT_LEN_SAT) : 10'(len_run);
        v.field_count  = 6'(commas + 6'd1);
        v.computed_xor = xor_run;
        v.received_sum = cksum_run;
        verdicts_due.push_back(v);
        open_sent  = 1'b0;
        cr_pending = 1'b0;
        clear_sentence();
    endtask

    task automatic track_byte(input logic [7:0] b);
        if (b == CHR_LF && cr_pending) begin
            close_sentence();
            return;
        end
        // A CR that was not followed by LF is plain body data
        if (cr_pending) begin
            cr_pending = 1'b0;
            fold_body(CHR_CR);
        end
        if (b == start_ch) begin
            clear_sentence();
            open_sent = 1'b1;
        end
        else if (b == CHR_CR) begin
            cr_pending = 1'b1;
        end
        else begin
            fold_body(b);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        sentence_verdict_t want;
        if (!rst_n) begin
            start_ch   = START_CHAR_RST;
            min_len    = MIN_BODY_LEN_RST;
            open_sent  = 1'b0;
            cr_pending = 1'b0;
            clear_sentence();
            verdicts_due.delete();
            pending <= 0;
        end
        else begin
            if (out_valid && out_ready) begin
                if (verdicts_due.size() == 0) begin
                    $error("result beat with no sentence verdict waiting");
                    errs++;
                end
                else begin
                    want = verdicts_due.pop_front();
                    if (out_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, out_status);
                        errs++;
                    end
                    if (out_msg_type !== want.msg_type) begin
                        $error("msg_type: expected %0d, got %0d", want.msg_type, out_msg_type);
                        errs++;
                    end
                    if (out_body_length !== want.body_length) begin
                        $error("body_length: expected %0d, got %0d",
                               want.body_length, out_body_length);
                        errs++;
                    end
                    if (out_field_count !== want.field_count) begin
                        $error("field_count: expected %0d, got %0d",
                               want.field_count, out_field_count);
                        errs++;
                    end
                    if (out_computed_xor !== want.computed_xor) begin
                        $error("computed_xor: expected 0x%02h, got 0x%02h",
                               want.computed_xor, out_computed_xor);
                        errs++;
                    end
                    if (out_received_sum !== want.received_sum) begin
                        $error("received_sum: expected 0x%02h, got 0x%02h",
                               want.received_sum, out_received_sum);
                        errs++;
                    end
                end
            end
            if (in_valid && in_ready) begin
                track_byte(in_byte);
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_START_CHAR:   start_ch = cfg_wdata;
                    CFG_MIN_BODY_LEN: min_len  = cfg_wdata;
                    default:          ;
                endcase
            end
            pending    <= verdicts_due.size();
            fail_count <= errs;
        end
    end

endmodule

FILE: verif/tb_top.sv
// ============================================================================
// tb_top - NMEA sentence checker testbench
// Streams directed and random byte sequences into the checker under several
// register settings and idle patterns; a verdict monitor beside the block
// predicts and checks every result beat.
// ============================================================================
module tb_top;
    import nsc_pkg::*;

    // Cycles to let the byte and result registers drain after the last
    // expected result, before touching registers or ending the run
    localparam int SETTLE_CYCLES = 8;
    // Hard stop: far beyond the slowest legal run of about 3k bytes
    localparam int RUN_LIMIT = 4_000_000;

    localparam logic [7:0] OPENING [24] = '{
        // CR LF with no open sentence
        CHR_CR, CHR_LF,
        // empty body
        "$", CHR_CR, CHR_LF,
        // lone CR, zero byte, all-ones byte, mixed case hex digits
        "$", "x", CHR_CR, 8'h00, 8'hFF, CHR_STAR, "f", "F", CHR_CR, CHR_LF,
        // two stars
        "$", "a", "b", "c", CHR_STAR, CHR_STAR, "0", CHR_CR, CHR_LF
    };

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [7:0]              cfg_wdata;
    int                      fail_count;
    int                      pending;

    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         beats_sent = 0;
    logic [7:0] cur_start = START_CHAR_RST;
    logic [7:0] body_xor;

    nsc_in_if  rx ();
    nsc_out_if result ();

    nmea_sentence_checker_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    nsc_verdict_monitor u_monitor (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (rx.valid),
        .in_ready         (rx.ready),
        .in_byte          (rx.rx_byte),
        .out_valid        (result.valid),
        .out_ready        (result.ready),
        .out_status       (result.status),
        .out_msg_type     (result.msg_type),
        .out_body_length  (result.body_length),
        .out_field_count  (result.field_count),
        .out_computed_xor (result.computed_xor),
        .out_received_sum (result.received_sum),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .fail_count       (fail_count),
        .pending          (pending)
    );

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure
    initial
    begin
        #(RUN_LIMIT);
        $display("nmea_sentence_checker_unit test failed");
        $finish;
    end

    // Result side: stall at random, one fresh decision per edge
    initial
    begin
        result.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            result.ready <= (int'($urandom_range(99)) >= recv_stall_pct);
        end
    end

    // Offer one byte beat; idle first at random, then hold valid until taken.
    // Valid is left high so back-to-back beats never drop it within a step.
    task automatic send_byte(input logic [7:0] b);
        while (int'($urandom_range(99)) < send_idle_pct)
        begin
            rx.valid <= 1'b0;
            @(posedge clk);
        end
        rx.valid   <= 1'b1;
        rx.rx_byte <= b;
        @(posedge clk);
        while (!rx.ready)
        begin
            @(posedge clk);
        end
        beats_sent++;
    endtask

    // Body byte before the star: fold it into the running checksum
    task automatic put_body(input logic [7:0] b);
        body_xor = body_xor ^ b;
        send_byte(b);
    endtask

    // Printable field text that never opens, splits or closes a sentence
    function automatic logic [7:0] text_char();
        logic [7:0] c;
        do
        begin
            c = 8'($urandom_range(8'h7E, 8'h20));
        end
        while (c == CHR_STAR || c == CHR_COMMA || c == cur_start);
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input logic lower);
        if (v < 4'd10) begin
            return 8'("0" + v);
        end
        return lower ? 8'("a" + v - 10) : 8'("A" + v - 10);
    endfunction

    // Drop valid, wait out every expected result, then let the pipeline
    // empty of bytes that cause no result
    task automatic settle();
        rx.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One sentence, mostly well formed with random content; the rest is
    // raw noise or a sentence broken around the checksum
    task automatic send_sentence();
        int         shape;
        int         tail;
        int         nfields;
        logic       lower;
        logic [7:0] sum_sent;
        shape = $urandom_range(99);
        if (shape < 12)
        begin
            // Raw bytes over the whole code space, sometimes closed by CR LF
            repeat ($urandom_range(12, 1)) send_byte(8'($urandom_range(255)));
            if ($urandom_range(1))
            begin
                send_byte(CHR_CR);
                send_byte(CHR_LF);
            end
            return;
        end
        body_xor = '0;
        send_byte(cur_start);
        // Talker id
        if ($urandom_range(99) < 80)
        begin
            put_body("G");
            put_body("P");
        end
        else
        begin
            put_body(text_char());
            put_body(text_char());
        end
        // Message type letters, three random letters, or a first field too short to hold them
        case ($urandom_range(5))
            0: begin put_body("G"); put_body("G"); put_body("A"); end
            1: begin put_body("A"); put_body("T"); put_body("T"); end
            2: begin put_body("G"); put_body("S"); put_body("V"); end
            3: begin put_body("R"); put_body("M"); put_body("C"); end
            4: repeat (3) put_body(text_char());
            default: repeat ($urandom_range(2)) put_body(text_char());
        endcase
        // A few sentences carry 38 to 45 commas, most of them enough to saturate the field count
        nfields = (shape < 15) ? $urandom_range(45, 38) : $urandom_range(6);
        repeat (nfields)
        begin
            put_body(CHR_COMMA);
            repeat ($urandom_range(5)) put_body(text_char());
        end
        // Checksum tail: mostly two digits, some correct and some not
        tail     = $urandom_range(99);
        lower    = 1'($urandom_range(1));
        sum_sent = body_xor;
        if ($urandom_range(99) < 25)
        begin
            sum_sent = body_xor ^ 8'($urandom_range(255, 1));
        end
        if (tail < 97)
        begin
            send_byte(CHR_STAR);
            // extra leading digit: only the low byte of the value counts
            if (tail >= 88 && tail <= 90)
            begin
                send_byte(hex_char(4'($urandom_range(15)), lower));
            end
            if (tail >= 85 && tail <= 87)
            begin
                send_byte(hex_char(sum_sent[3:0], lower));
            end
            else if (tail < 80 || tail >= 88)
            begin
                send_byte(hex_char(sum_sent[7:4], lower));
                send_byte(hex_char(sum_sent[3:0], lower));
            end
            // second star, then junk after the digits
            if (tail >= 91 && tail <= 93)
            begin
                send_byte(CHR_STAR);
            end
            if (tail >= 91)
            begin
                repeat ($urandom_range(3, 1)) send_byte(text_char());
            end
        end
        send_byte(CHR_CR);
        send_byte(CHR_LF);
    endtask

    // Long valid RMC sentence with a correct checksum
    task automatic send_long(input int n);
        body_xor = '0;
        send_byte(cur_start);
        put_body("G");
        put_body("P");
        put_body("R");
        put_body("M");
        put_body("C");
        repeat (n) put_body(text_char());
        send_byte(CHR_STAR);
        send_byte(hex_char(body_xor[7:4], 1'b0));
        send_byte(hex_char(body_xor[3:0], 1'b0));
        send_byte(CHR_CR);
        send_byte(CHR_LF);
    endtask

    // Hold the sender until the block is idle, write both registers, set the idle and stall
    // patterns, send the long sentence if one is asked for, then stream sentences until the byte budget is spent
    task automatic run_phase(input logic [7:0] start, input logic [7:0] min_len,
                             input int idle_pct, input int stall_pct,
                             input int long_len, input int budget);
        int mark;
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_START_CHAR;
        cfg_wdata <= start;
        @(posedge clk);
        cfg_index <= CFG_MIN_BODY_LEN;
        cfg_wdata <= min_len;
        @(posedge clk);
        cfg_we         <= 1'b0;
        cur_start      = start;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        if (long_len > 0)
        begin
            send_long(long_len);
        end
        mark = beats_sent + budget;
        while (beats_sent < mark)
        begin
            send_sentence();
        end
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        rx.valid   <= 1'b0;
        rx.rx_byte <= '0;
        cfg_we     <= 1'b0;
        cfg_index  <= CFG_START_CHAR;
        cfg_wdata  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening under reset register values
        foreach (OPENING[i])
        begin
            send_byte(OPENING[i]);
        end

        // No idling, no minimum length
        run_phase("!", 8'd0, 0, 0, 0, 200);
        // Zero byte opens sentences; sender idles
        run_phase(8'h00, 8'd10, 59, 0, 0, 200);
        // All-ones byte opens sentences; receiver stalls
        run_phase(8'hFF, 8'd3, 0, 59, 0, 200);
        // LF as start: a pending CR still wins and closes the sentence
        run_phase(CHR_LF, 8'd6, 35, 35, 0, 150);
        // CR as start: every CR restarts, so no sentence ever closes
        run_phase(CHR_CR, 8'd6, 0, 0, 0, 40);
        // Largest minimum; one body long enough to saturate the length
        run_phase("$", 8'd255, 35, 35, 1030, 60);
        // Back to the usual start with a small random minimum
        run_phase("$", 8'($urandom_range(20, 1)), 59, 0, 0, 250);

        // Drain everything still in flight, then give the verdict
        settle();
        if (fail_count == 0)
        begin
            $display("nmea_sentence_checker_unit test passed");
        end
        else
        begin
            $display("nmea_sentence_checker_unit test failed");
        end
        $finish;
    end

endmodule
